>>> rtl/core/fpa_pkg.sv
package fpa_pkg;

   localparam int FracBits = 8;
   localparam int WordBits = 32;
   localparam int QuoBits  = WordBits + FracBits + 1;
   localparam int NumBits  = WordBits + FracBits + 1;
   localparam int DenBits  = WordBits + 1;
   localparam int RemBits  = DenBits + 1;
   localparam int ProdBits = 2 * WordBits;

   localparam logic [3:0] OP_ADD      = 4'd0;
   localparam logic [3:0] OP_SUB      = 4'd1;
   localparam logic [3:0] OP_MUL      = 4'd2;
   localparam logic [3:0] OP_DIV      = 4'd3;
   localparam logic [3:0] OP_MIN      = 4'd4;
   localparam logic [3:0] OP_MAX      = 4'd5;
   localparam logic [3:0] OP_CMP      = 4'd6;
   localparam logic [3:0] OP_INC      = 4'd7;
   localparam logic [3:0] OP_DEC      = 4'd8;
   localparam logic [3:0] OP_TO_INT   = 4'd9;
   localparam logic [3:0] OP_FROM_INT = 4'd10;

   // work carried down the divider chain
   typedef struct packed {
      logic                    valid;
      logic [3:0]              operation;
      logic [WordBits-1:0]     operand_a;
      logic [WordBits-1:0]     operand_b;
      logic [NumBits-1:0]      num;
      logic [DenBits-1:0]      den;
      logic [RemBits-1:0]      rem;
      logic [QuoBits-1:0]      quo;
      logic [ProdBits-1:0]     prod;
   } stage_type;

endpackage

>>> rtl/core/fpa_cell.sv
// one restoring divide step per cell, payload carried along
module fpa_cell (
   input  logic                clock,
   input  logic                reset,
   input  fpa_pkg::stage_type  stage_in,
   output fpa_pkg::stage_type  stage_out
);

   fpa_pkg::stage_type stage_ff;
   fpa_pkg::stage_type stage_in_w;
   logic [fpa_pkg::RemBits-1:0] trial;
   logic [fpa_pkg::RemBits-1:0] diff;

   // shift in next dividend bit and try subtract (remainder holds 2*rem form)
   always_comb begin
      stage_in_w = stage_in;
      trial = {stage_in.rem[fpa_pkg::RemBits-2:0], stage_in.num[fpa_pkg::NumBits-1]};
      diff  = trial - {1'b0, stage_in.den};
      stage_in_w.num = {stage_in.num[fpa_pkg::NumBits-2:0], 1'b0};
      if (!diff[fpa_pkg::RemBits-1]) begin
         stage_in_w.rem = diff;
         stage_in_w.quo = {stage_in.quo[fpa_pkg::QuoBits-2:0], 1'b1};
      end else begin
         stage_in_w.rem = trial;
         stage_in_w.quo = {stage_in.quo[fpa_pkg::QuoBits-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;

endmodule

>>> rtl/core/fixed_point_alu_unit.sv
// result strobe follows the entry register, the divider chain and the result register; Q24.8 operands
// throughput: one beat per cycle; busy is never raised
// the divider is a chain of one-bit cells, one per quotient bit, set by the divide
// reset: synchronous active high, clears all valid bits; the receiver cannot stall
module fixed_point_alu_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [3:0]          req_operation,
   input  logic signed [31:0]  req_operand_a,
   input  logic signed [31:0]  req_operand_b,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_result,
   output logic                rsp_a_less,
   output logic                rsp_a_equal,
   output logic                rsp_a_greater,
   output logic                rsp_overflow,
   output logic                rsp_divide_by_zero
);

   localparam int N  = fpa_pkg::NumBits;
   localparam int W  = fpa_pkg::WordBits;
   localparam int F  = fpa_pkg::FracBits;
   localparam int PB = fpa_pkg::ProdBits;

   fpa_pkg::stage_type entry_ff, entry_in;
   fpa_pkg::stage_type chain [0:N];

   logic [W-1:0] mag_a, mag_b;

   assign busy = 1'b0;
   assign mag_a = req_operand_a[W-1] ? W'(-req_operand_a) : req_operand_a;
   assign mag_b = req_operand_b[W-1] ? W'(-req_operand_b) : req_operand_b;

   // entry stage: magnitudes, product, divider operands
   always_comb begin
      entry_in.valid     = start;
      entry_in.operation = req_operation;
      entry_in.operand_a = req_operand_a;
      entry_in.operand_b = req_operand_b;
      entry_in.num       = {{(N-W){1'b0}}, mag_a} << F;
      entry_in.den       = {1'b0, mag_b};
      entry_in.rem       = '0;
      entry_in.quo       = '0;
      entry_in.prod      = PB'(mag_a) * PB'(mag_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   // divider chain, one quotient bit per cell
   assign chain[0] = entry_ff;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         fpa_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .stage_in (chain[g]),
            .stage_out(chain[g+1])
         );
      end
   endgenerate

   // final stage: rounding, saturation, op select
   fpa_pkg::stage_type last;
   logic signed [W-1:0] a, b;
   logic signed [W:0]   sum_w, dif_w, inc_w, dec_w;
   logic [PB-1:0]       prod_r;
   logic [PB:0]         mmag;
   logic [fpa_pkg::QuoBits:0] qmag;
   logic                neg;
   logic [W:0]          fmag;
   logic signed [W-1:0] r_in;
   logic                ov_in, dz_in;
   logic signed [W-1:0] max_v, min_v;

   assign last  = chain[N];
   assign a     = last.operand_a;
   assign b     = last.operand_b;
   assign max_v = {1'b0, {(W-1){1'b1}}};
   assign min_v = {1'b1, {(W-1){1'b0}}};
   assign neg   = a[W-1] ^ b[W-1];

   // saturate a magnitude with a sign
   function automatic logic [W:0] sat_mag(input logic [PB:0] m, input logic n);
      logic [W:0] o;
      if (n) begin
         if (m > (PB+1)'({1'b1, {(W-1){1'b0}}})) o = {1'b1, min_v};
         else o = {1'b0, W'(-m[W-1:0])};
      end else begin
         if (m > (PB+1)'(max_v)) o = {1'b1, max_v};
         else o = {1'b0, m[W-1:0]};
      end
      return o;
   endfunction

   always_comb begin
      sum_w  = {a[W-1], a} + {b[W-1], b};
      dif_w  = {a[W-1], a} - {b[W-1], b};
      inc_w  = {a[W-1], a} + (W+1)'(1);
      dec_w  = {a[W-1], a} - (W+1)'(1);
      prod_r = last.prod + PB'((F > 0) ? (1 << (F-1)) : 0);
      mmag   = (PB+1)'(prod_r >> F);
      // round the magnitude half up: q + (2*rem >= den)
      qmag   = {1'b0, last.quo} +
               (fpa_pkg::QuoBits+1)'({last.rem, 1'b0} >= {1'b0, last.den, 1'b0} >> 1
                  && ({last.rem, 1'b0} >= {2'b0, last.den}));
      r_in  = '0;
      ov_in = 1'b0;
      dz_in = 1'b0;
      fmag  = '0;
      case (last.operation)
         fpa_pkg::OP_ADD: begin
            r_in  = (sum_w[W] != sum_w[W-1]) ? (sum_w[W] ? min_v : max_v) : sum_w[W-1:0];
            ov_in = sum_w[W] != sum_w[W-1];
         end
         fpa_pkg::OP_SUB: begin
            r_in  = (dif_w[W] != dif_w[W-1]) ? (dif_w[W] ? min_v : max_v) : dif_w[W-1:0];
            ov_in = dif_w[W] != dif_w[W-1];
         end
         fpa_pkg::OP_MUL: begin
            fmag  = sat_mag(mmag, neg);
            r_in  = fmag[W-1:0];
            ov_in = fmag[W];
         end
         fpa_pkg::OP_DIV: begin
            if (b == '0) begin
               dz_in = 1'b1;
            end else begin
               fmag  = sat_mag((PB+1)'(qmag), neg);
               r_in  = fmag[W-1:0];
               ov_in = fmag[W];
            end
         end
         fpa_pkg::OP_MIN: r_in = (a < b) ? a : b;
         fpa_pkg::OP_MAX: r_in = (a > b) ? a : b;
         fpa_pkg::OP_CMP: r_in = '0;
         fpa_pkg::OP_INC: begin
            r_in  = inc_w[W] != inc_w[W-1] ? max_v : inc_w[W-1:0];
            ov_in = inc_w[W] != inc_w[W-1];
         end
         fpa_pkg::OP_DEC: begin
            r_in  = dec_w[W] != dec_w[W-1] ? min_v : dec_w[W-1:0];
            ov_in = dec_w[W] != dec_w[W-1];
         end
         fpa_pkg::OP_TO_INT: begin
            r_in = a[W-1] ? W'(-((W'(-a)) >> F)) : (a >>> F);
         end
         fpa_pkg::OP_FROM_INT: begin
            fmag  = sat_mag((PB+1)'({1'b0, (a[W-1] ? W'(-a) : a)}) << F, a[W-1]);
            r_in  = fmag[W-1:0];
            ov_in = fmag[W];
         end
         default: r_in = '0;
      endcase
   end

   logic                valid_ff;
   logic signed [W-1:0] result_ff;
   logic [4:0]          flags_ff;

   always_ff @(posedge clock) begin
      result_ff <= r_in;
      flags_ff  <= {a < b, a == b, a > b, ov_in, dz_in};
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= last.valid;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result         = result_ff;
   assign rsp_a_less         = flags_ff[4];
   assign rsp_a_equal        = flags_ff[3];
   assign rsp_a_greater      = flags_ff[2];
   assign rsp_overflow       = flags_ff[1];
   assign rsp_divide_by_zero = flags_ff[0];

endmodule
